[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the panel heap.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, disabled while arst_n is low.
`define AST_IMPLY(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on clk, disabled while arst_n is low.
`define AST_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[rtl/core/pmh_pkg.sv]
// Types and constants of the panel max-heap.
package pmh_pkg;

	localparam int KEY_W  = 63;
	localparam int WORD_W = 64;
	localparam int OCC_W  = 9;

	localparam logic FN_PUSH = 1'b0;
	localparam logic FN_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} stat_t;

	typedef struct packed {
		logic [WORD_W-1:0] left;
		logic [WORD_W-1:0] right;
		logic [WORD_W-1:0] re;
		logic [WORD_W-1:0] im;
	} pay_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		pay_t             pay;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_CMP,
		S_POP_ROOT,
		S_POP_LAST,
		S_DN_CMPL,
		S_DN_CMPR,
		S_DN_MOVE,
		S_FIN,
		S_DONE
	} state_t;

endpackage

[rtl/core/pmh_store.sv]
// Heap entry storage: key memory with two read ports, payload memory with one.
module pmh_store #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic                    clk,
	input  logic                    wr_en,
	input  logic [AW-1:0]           wr_addr,
	input  pmh_pkg::entry_t         wr_data,
	input  logic [AW-1:0]           key_a_addr,
	input  logic [AW-1:0]           key_b_addr,
	input  logic [AW-1:0]           pay_addr,
	output logic [pmh_pkg::KEY_W-1:0] key_a,
	output logic [pmh_pkg::KEY_W-1:0] key_b,
	output pmh_pkg::pay_t           pay
);

	logic [pmh_pkg::KEY_W-1:0] key_mem [DEPTH];
	pmh_pkg::pay_t             pay_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_data.key;
			pay_mem[wr_addr] <= wr_data.pay;
		end
	end

	always_ff @(posedge clk) begin
		key_a <= key_mem[key_a_addr];
		key_b <= key_mem[key_b_addr];
		pay   <= pay_mem[pay_addr];
	end

endmodule

[rtl/core/panel_max_heap.sv]
// Top level of the panel max-heap: sequencer, shared key comparator, result register.
//
// Request channel (req_valid / req_stall): func selects push (0) or pop (1); a push
// carries err_key and four opaque payload words, a pop ignores them. An item is
// taken when req_valid is high and req_stall low; req_stall is high while an
// operation is in flight, so the block takes one item at a time.
// Response channel (rsp_valid / rsp_stall): exactly one item per request with
// status, the popped entry (zero on a push or failed pop) and the occupancy.
// Steps per operation:
//   push: the entry climbs one level per cycle (read, compare, hole write).
//   pop:  a level is a child-key read, two comparator passes (left, then right
//   child) and a move; the sift ends on a leaf or above smaller children.
//   A refused push or an empty pop goes straight to the response.
//   A push to a full heap or a pop on an empty one leaves the heap untouched.
// The sifts use a moving hole: the sifted entry sits in a register and is
// written once at its final place, so each level costs one memory write.
// The response sits in an output register; the next request is taken while it
// waits, and the sequencer holds in its last state only if a new response is
// ready before the receiver has drained the old one.
// Reset clears the entry count, the response valid flag and the sequencer; the
// entry memories need no clearing since only entries below the count are ever used.
module panel_max_heap #(
	parameter int CAPACITY = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic                       func,
	input  logic [pmh_pkg::KEY_W-1:0]  err_key,
	input  logic [pmh_pkg::WORD_W-1:0] left_end,
	input  logic [pmh_pkg::WORD_W-1:0] right_end,
	input  logic [pmh_pkg::WORD_W-1:0] value_re,
	input  logic [pmh_pkg::WORD_W-1:0] value_im,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic [1:0]                 status,
	output logic [pmh_pkg::KEY_W-1:0]  out_key,
	output logic [pmh_pkg::WORD_W-1:0] out_left,
	output logic [pmh_pkg::WORD_W-1:0] out_right,
	output logic [pmh_pkg::WORD_W-1:0] out_re,
	output logic [pmh_pkg::WORD_W-1:0] out_im,
	output logic [pmh_pkg::OCC_W-1:0]  occupancy
);

	`include "assert_macros.svh"

	localparam int AW  = $clog2(CAPACITY);   // entry index
	localparam int CW  = $clog2(CAPACITY + 1); // entry count
	localparam int CHW = AW + 2;              // child index, never wraps

	// parent of a heap index (index must be nonzero)
	function automatic logic [AW-1:0] par_of(input logic [AW-1:0] idx);
		par_of = (idx - AW'(1)) >> 1;
	endfunction

	pmh_pkg::state_t state_q, state_d;
	logic [CW-1:0]   count_q;

	// sift datapath
	pmh_pkg::entry_t            mov_q;       // entry being sifted
	logic [AW-1:0]              hole_q;      // current hole
	logic [AW-1:0]              par_q;       // parent of hole during sift-up
	logic [AW-1:0]              lc_q, rc_q;  // children of hole during sift-down
	logic                       rc_ok_q;
	logic                       left_win_q;
	logic [pmh_pkg::KEY_W-1:0]  kr_q;
	logic [pmh_pkg::KEY_W-1:0]  best_key_q;
	logic [AW-1:0]              best_idx_q;

	// result being built, and the output register
	pmh_pkg::stat_t             res_status_q;
	logic [pmh_pkg::KEY_W-1:0]  res_key_q;
	pmh_pkg::pay_t              res_pay_q;
	logic                       out_valid_q;
	pmh_pkg::stat_t             out_status_q;
	logic [pmh_pkg::KEY_W-1:0]  out_key_q;
	pmh_pkg::pay_t              out_pay_q;
	logic [pmh_pkg::OCC_W-1:0]  out_occ_q;

	// memory ports
	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	pmh_pkg::entry_t            wr_data;
	logic [AW-1:0]              key_a_addr, key_b_addr, pay_addr;
	logic [pmh_pkg::KEY_W-1:0]  key_a, key_b;
	pmh_pkg::pay_t              pay_rd;

	// misc combinational
	logic                       accept;
	logic                       full;
	logic                       empty;
	logic [AW-1:0]              par_cnt;
	logic [AW-1:0]              next_hole;
	logic [CHW-1:0]             lc, rc, cnt_ext;
	logic                       lc_ok, rc_ok;
	logic [pmh_pkg::KEY_W-1:0]  cmp_a, cmp_b;
	logic                       cmp_gt;
	logic                       take_r;
	logic                       load_out;
	logic [CW+pmh_pkg::OCC_W-1:0] occ_ext;

	pmh_store #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_store (
		.clk        (clk),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.key_a_addr (key_a_addr),
		.key_b_addr (key_b_addr),
		.pay_addr   (pay_addr),
		.key_a      (key_a),
		.key_b      (key_b),
		.pay        (pay_rd)
	);

	assign req_stall = (state_q != pmh_pkg::S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign par_cnt   = par_of(count_q[AW-1:0]);
	assign load_out  = !out_valid_q || !rsp_stall;
	assign occ_ext   = {{pmh_pkg::OCC_W{1'b0}}, count_q};

	// children of the hole the sift-down is about to open
	assign next_hole = (state_q == pmh_pkg::S_POP_LAST) ? '0 : best_idx_q;
	assign lc        = CHW'({next_hole, 1'b1});
	assign rc        = lc + CHW'(1);
	assign cnt_ext   = CHW'(count_q);
	assign lc_ok     = (lc < cnt_ext);
	assign rc_ok     = (rc < cnt_ext);

	// the one key comparator, shared by both sifts
	always_comb begin
		unique case (state_q)
			pmh_pkg::S_DN_CMPL: begin
				cmp_a = key_a;
				cmp_b = mov_q.key;
			end
			pmh_pkg::S_DN_CMPR: begin
				cmp_a = kr_q;
				cmp_b = best_key_q;
			end
			default: begin
				cmp_a = mov_q.key;
				cmp_b = key_a;
			end
		endcase
	end
	assign cmp_gt = (cmp_a > cmp_b);
	assign take_r = rc_ok_q && cmp_gt;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pmh_pkg::S_IDLE: begin
				if (accept) begin
					if (func == pmh_pkg::FN_PUSH) begin
						if (full)       state_d = pmh_pkg::S_DONE;
						else if (empty) state_d = pmh_pkg::S_FIN;
						else            state_d = pmh_pkg::S_UP_CMP;
					end else begin
						state_d = empty ? pmh_pkg::S_DONE : pmh_pkg::S_POP_ROOT;
					end
				end
			end
			pmh_pkg::S_UP_CMP: begin
				if (!cmp_gt || par_q == '0) state_d = pmh_pkg::S_FIN;
			end
			pmh_pkg::S_POP_ROOT: state_d = pmh_pkg::S_POP_LAST;
			pmh_pkg::S_POP_LAST,
			pmh_pkg::S_DN_MOVE: state_d = lc_ok ? pmh_pkg::S_DN_CMPL : pmh_pkg::S_FIN;
			pmh_pkg::S_DN_CMPL: state_d = pmh_pkg::S_DN_CMPR;
			pmh_pkg::S_DN_CMPR: begin
				state_d = (take_r || left_win_q) ? pmh_pkg::S_DN_MOVE : pmh_pkg::S_FIN;
			end
			pmh_pkg::S_FIN: state_d = pmh_pkg::S_DONE;
			pmh_pkg::S_DONE: begin
				if (load_out) state_d = pmh_pkg::S_IDLE;
			end
			default: state_d = pmh_pkg::S_IDLE;
		endcase
	end

	// memory addresses and writes
	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = hole_q;
		wr_data    = mov_q;
		key_a_addr = '0;
		key_b_addr = '0;
		pay_addr   = '0;
		unique case (state_q)
			pmh_pkg::S_IDLE: begin
				// root for a pop, parent of the new slot for a push
				key_a_addr = (func == pmh_pkg::FN_POP) ? '0 : par_cnt;
				pay_addr   = key_a_addr;
			end
			pmh_pkg::S_UP_CMP: begin
				key_a_addr = par_of(par_q);
				pay_addr   = key_a_addr;
				if (cmp_gt) begin
					wr_en   = 1'b1;
					wr_data = '{key: key_a, pay: pay_rd};
				end
			end
			pmh_pkg::S_POP_ROOT: begin
				// count is already decremented: it indexes the last entry
				key_a_addr = count_q[AW-1:0];
				pay_addr   = count_q[AW-1:0];
			end
			pmh_pkg::S_POP_LAST: begin
				key_a_addr = lc_ok ? lc[AW-1:0] : '0;
				key_b_addr = rc_ok ? rc[AW-1:0] : key_a_addr;
			end
			pmh_pkg::S_DN_MOVE: begin
				key_a_addr = lc_ok ? lc[AW-1:0] : '0;
				key_b_addr = rc_ok ? rc[AW-1:0] : key_a_addr;
				wr_en      = 1'b1;
				wr_data    = '{key: best_key_q, pay: pay_rd};
			end
			pmh_pkg::S_DN_CMPR: begin
				pay_addr = take_r ? rc_q : lc_q;
			end
			pmh_pkg::S_FIN: begin
				wr_en = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pmh_pkg::S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (func == pmh_pkg::FN_PUSH && !full)     count_q <= count_q + CW'(1);
				else if (func == pmh_pkg::FN_POP && !empty) count_q <= count_q - CW'(1);
			end
			if (state_q == pmh_pkg::S_DONE && load_out) out_valid_q <= 1'b1;
			else if (!rsp_stall)                         out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			pmh_pkg::S_IDLE: begin
				if (accept) begin
					mov_q     <= '{key: err_key,
						pay: '{left: left_end, right: right_end, re: value_re, im: value_im}};
					hole_q    <= count_q[AW-1:0];
					par_q     <= par_cnt;
					res_key_q <= '0;
					res_pay_q <= '0;
					if (func == pmh_pkg::FN_PUSH) res_status_q <= full ? pmh_pkg::ST_FULL : pmh_pkg::ST_OK;
					else res_status_q <= empty ? pmh_pkg::ST_EMPTY : pmh_pkg::ST_OK;
				end
			end
			pmh_pkg::S_UP_CMP: begin
				if (cmp_gt) begin
					hole_q <= par_q;
					par_q  <= par_of(par_q);
				end
			end
			pmh_pkg::S_POP_ROOT: begin
				res_key_q <= key_a;
				res_pay_q <= pay_rd;
			end
			pmh_pkg::S_POP_LAST: begin
				mov_q   <= '{key: key_a, pay: pay_rd};
				hole_q  <= '0;
				lc_q    <= lc[AW-1:0];
				rc_q    <= rc[AW-1:0];
				rc_ok_q <= rc_ok;
			end
			pmh_pkg::S_DN_CMPL: begin
				left_win_q <= cmp_gt;
				best_key_q <= cmp_gt ? key_a : mov_q.key;
				kr_q       <= key_b;
			end
			pmh_pkg::S_DN_CMPR: begin
				best_idx_q <= take_r ? rc_q : lc_q;
				if (take_r) best_key_q <= kr_q;
			end
			pmh_pkg::S_DN_MOVE: begin
				hole_q  <= best_idx_q;
				lc_q    <= lc[AW-1:0];
				rc_q    <= rc[AW-1:0];
				rc_ok_q <= rc_ok;
			end
			pmh_pkg::S_DONE: begin
				if (load_out) begin
					out_status_q <= res_status_q;
					out_key_q    <= res_key_q;
					out_pay_q    <= res_pay_q;
					out_occ_q    <= occ_ext[pmh_pkg::OCC_W-1:0];
				end
			end
			default: begin
				hole_q <= hole_q;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;
	assign status    = out_status_q;
	assign out_key   = out_key_q;
	assign out_left  = out_pay_q.left;
	assign out_right = out_pay_q.right;
	assign out_re    = out_pay_q.re;
	assign out_im    = out_pay_q.im;
	assign occupancy = out_occ_q;

	`AST_IMPLY(a_count_bound, 1'b1, count_q <= CW'(CAPACITY))
	`AST_NEXT(a_busy_after_accept, accept, state_q != pmh_pkg::S_IDLE)
	`AST_NEXT(a_push_grows, accept && func == pmh_pkg::FN_PUSH && !full,
		count_q == $past(count_q) + CW'(1))
	`AST_IMPLY(a_fail_no_data, rsp_valid && out_status_q != pmh_pkg::ST_OK,
		out_key_q == '0 && out_pay_q == '0)

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the panel max-heap: shadow heap, paced stimulus, response check.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEY_W  = pmh_pkg::KEY_W;
	localparam int WORD_W = pmh_pkg::WORD_W;
	localparam int OCC_W  = pmh_pkg::OCC_W;

	localparam int HEAP_CAP = 256;
	localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
	// No new random phase starts once this many random items have been accepted.
	localparam int RANDOM_ITEMS = 1500;
	// Worst response is a pop sifting 7 levels; allow margin.
	localparam int DRAIN_CYCLES = 64;

	// One owed response: what the heap must answer for one accepted item.
	typedef struct {
		pmh_pkg::stat_t   status;
		pmh_pkg::entry_t  ent;
		logic [OCC_W-1:0] occ;
	} heap_rsp_t;

	// Shadow heap plus the queue of responses the block still owes.
	class heap_tracker;
		pmh_pkg::entry_t slots [HEAP_CAP];
		int unsigned     count;
		heap_rsp_t       owed [$];
		int unsigned     errors;

		function new();
			count  = 0;
			errors = 0;
		endfunction

		function void swap_slots(int unsigned a, int unsigned b);
			pmh_pkg::entry_t t;
			t        = slots[a];
			slots[a] = slots[b];
			slots[b] = t;
		endfunction

		// Applies one accepted item to the shadow heap and queues its response.
		function void apply_request(logic f, logic [KEY_W-1:0] k, pmh_pkg::pay_t p);
			heap_rsp_t   r;
			int unsigned pos, par, lc, rc, best;
			r.status = pmh_pkg::ST_OK;
			r.ent    = '0;
			if (f == pmh_pkg::FN_PUSH) begin
				if (count >= HEAP_CAP) begin
					r.status = pmh_pkg::ST_FULL;
				end else begin
					pos            = count;
					slots[pos].key = k;
					slots[pos].pay = p;
					count++;
					// sift up; an equal parent stops it
					while (pos > 0) begin
						par = (pos - 1) / 2;
						if (slots[par].key >= slots[pos].key)
							break;
						swap_slots(par, pos);
						pos = par;
					end
				end
			end else if (count == 0) begin
				r.status = pmh_pkg::ST_EMPTY;
			end else begin
				r.ent = slots[0];
				count--;
				slots[0] = slots[count];
				pos      = 0;
				// sift down; only a strictly larger child moves, left wins ties
				forever begin
					lc   = 2 * pos + 1;
					rc   = lc + 1;
					best = pos;
					if (lc < count && slots[lc].key > slots[best].key)
						best = lc;
					if (rc < count && slots[rc].key > slots[best].key)
						best = rc;
					if (best == pos)
						break;
					swap_slots(best, pos);
					pos = best;
				end
			end
			r.occ = count[OCC_W-1:0];
			owed.push_back(r);
		endfunction

		task flag_mismatch(string what);
			if (errors < 40)
				$display("mismatch @%0t: %s", $realtime, what);
			errors++;
		endtask

		// Compares one accepted response with the oldest owed one.
		task match_response(logic [1:0] st, logic [KEY_W-1:0] k, pmh_pkg::pay_t p,
				logic [OCC_W-1:0] occ);
			heap_rsp_t e;
			if (owed.size() == 0) begin
				flag_mismatch("response with no item outstanding");
				return;
			end
			e = owed.pop_front();
			if (st !== e.status)
				flag_mismatch($sformatf("status %0d, want %0d", st, e.status));
			if (k !== e.ent.key)
				flag_mismatch($sformatf("out_key %h, want %h", k, e.ent.key));
			if (p.left !== e.ent.pay.left)
				flag_mismatch($sformatf("out_left %h, want %h", p.left, e.ent.pay.left));
			if (p.right !== e.ent.pay.right)
				flag_mismatch($sformatf("out_right %h, want %h", p.right, e.ent.pay.right));
			if (p.re !== e.ent.pay.re)
				flag_mismatch($sformatf("out_re %h, want %h", p.re, e.ent.pay.re));
			if (p.im !== e.ent.pay.im)
				flag_mismatch($sformatf("out_im %h, want %h", p.im, e.ent.pay.im));
			if (occ !== e.occ)
				flag_mismatch($sformatf("occupancy %0d, want %0d", occ, e.occ));
		endtask
	endclass

	// Clock, reset and every block input start at a known value.
	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic               func      = pmh_pkg::FN_PUSH;
	logic [KEY_W-1:0]   err_key   = '0;
	logic [WORD_W-1:0]  left_end  = '0;
	logic [WORD_W-1:0]  right_end = '0;
	logic [WORD_W-1:0]  value_re  = '0;
	logic [WORD_W-1:0]  value_im  = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic [1:0]         status;
	logic [KEY_W-1:0]   out_key;
	logic [WORD_W-1:0]  out_left;
	logic [WORD_W-1:0]  out_right;
	logic [WORD_W-1:0]  out_re;
	logic [WORD_W-1:0]  out_im;
	logic [OCC_W-1:0]   occupancy;

	heap_tracker tracker = new();

	// Sender pacing: items left in the current burst, random items accepted.
	int unsigned burst_left = 0;
	int unsigned random_sent = 0;

	panel_max_heap #(
		.CAPACITY(HEAP_CAP)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.func      (func),
		.err_key   (err_key),
		.left_end  (left_end),
		.right_end (right_end),
		.value_re  (value_re),
		.value_im  (value_im),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.out_key   (out_key),
		.out_left  (out_left),
		.out_right (out_right),
		.out_re    (out_re),
		.out_im    (out_im),
		.occupancy (occupancy)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Key mix: wide random keys for deep sifts, a tiny range for many equal
	// keys (tie handling), the two extremes, and a band just under the maximum.
	function automatic logic [KEY_W-1:0] pick_key();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 50)
			return KEY_W'({$urandom, $urandom});
		else if (sel < 75)
			return KEY_W'($urandom_range(0, 7));
		else if (sel < 85)
			return $urandom_range(0, 1) ? KEY_MAX : '0;
		else
			return KEY_MAX - KEY_W'($urandom_range(0, 15));
	endfunction

	function automatic pmh_pkg::pay_t pick_payload();
		pmh_pkg::pay_t p;
		p.left  = {$urandom, $urandom};
		p.right = {$urandom, $urandom};
		p.re    = {$urandom, $urandom};
		p.im    = {$urandom, $urandom};
		return p;
	endfunction

	// Presents one item at a falling edge and holds it until it is taken.
	// Bursts of random length, now and then a long one, are parted by random
	// gaps that are sometimes zero.
	task automatic send_item(logic f, logic [KEY_W-1:0] k, pmh_pkg::pay_t p);
		int unsigned gap;
		gap = 0;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
				: $urandom_range(1, 20);
		end
		burst_left--;
		repeat (gap) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		func      <= f;
		err_key   <= k;
		left_end  <= p.left;
		right_end <= p.right;
		value_re  <= p.re;
		value_im  <= p.im;
		do
			@(posedge clk);
		while (req_stall);
		tracker.apply_request(f, k, p);
	endtask

	// One random item; push_pct is the chance of a push. Pops carry junk fields.
	task automatic random_item(int unsigned push_pct);
		logic f;
		f = ($urandom_range(0, 99) < push_pct) ? pmh_pkg::FN_PUSH : pmh_pkg::FN_POP;
		send_item(f, pick_key(), pick_payload());
		random_sent++;
	endtask

	// Stimulus: reset, directed items, then random phases.
	initial begin : stimulus
		int unsigned mode, run, pct;

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed: pop on an empty heap first.
		send_item(pmh_pkg::FN_POP, '0, '0);
		// Both key extremes with all-ones and all-zero payloads.
		send_item(pmh_pkg::FN_PUSH, KEY_MAX, '1);
		send_item(pmh_pkg::FN_PUSH, '0, '0);
		// Equal keys: sift-up must stop at an equal parent.
		repeat (3) send_item(pmh_pkg::FN_PUSH, KEY_W'(5), pick_payload());
		// A second maximum key equal to the root.
		send_item(pmh_pkg::FN_PUSH, KEY_MAX, pick_payload());
		send_item(pmh_pkg::FN_PUSH, KEY_W'(6), pick_payload());
		// Drain all seven; payloads show which of the equal keys came first.
		repeat (7) send_item(pmh_pkg::FN_POP, pick_key(), pick_payload());
		send_item(pmh_pkg::FN_POP, KEY_MAX, '1);
		// Equal children on sift-down: the left one must win.
		repeat (3) send_item(pmh_pkg::FN_PUSH, KEY_W'(4), pick_payload());
		send_item(pmh_pkg::FN_PUSH, KEY_W'(1), pick_payload());
		repeat (4) send_item(pmh_pkg::FN_POP, '0, '0);

		// Random: fill to capacity, push into the full heap, drain past empty.
		while (tracker.count < HEAP_CAP)
			random_item(100);
		repeat (4) random_item(100);
		while (tracker.count > 0)
			random_item(0);
		repeat (3) random_item(0);

		// Then phases leaning toward growth, shrinkage or balance.
		while (random_sent < RANDOM_ITEMS) begin
			mode = $urandom_range(0, 2);
			run  = $urandom_range(40, 300);
			pct  = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
			repeat (run) random_item(pct);
		end

		@(negedge clk);
		req_valid <= 1'b0;

		// Wait out every owed response, then give stray ones time to show.
		while (tracker.owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Receiver stall pattern: runs of free flow, light random stalls, a fixed
	// periodic pattern that stalls three quarters of the time, and heavy random stalls.
	initial begin : rsp_pacer
		int unsigned mode, run, k;
		forever begin
			mode = $urandom_range(0, 3);
			run  = $urandom_range(10, 80);
			for (k = 0; k < run; k++) begin
				@(negedge clk);
				case (mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 2) == 0);
					2: rsp_stall <= ((k % 16) < 12);
					default: rsp_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Response capture: values seen at the rising edge are the pre-edge ones.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			tracker.match_response(status, out_key,
				pmh_pkg::pay_t'({out_left, out_right, out_re, out_im}), occupancy);
	end

	// Hang guard: well beyond the slowest legal run.
	initial begin : watchdog
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
